[rtl/core/fcd_pkg.sv]
// Package for the NOR flash command decoder.
// Holds the item structs, operation codes and command constants; no dependencies.

package fcd_pkg;

  localparam int unsigned AddrWidth = 25;
  localparam int unsigned DataWidth = 8;
  localparam int unsigned CfgIdxWidth = 2;

  // Configuration register indexes
  localparam logic [CfgIdxWidth-1:0] CfgManufacturer = 2'd0;
  localparam logic [CfgIdxWidth-1:0] CfgDevice       = 2'd1;
  localparam logic [CfgIdxWidth-1:0] CfgProtect      = 2'd2;

  // Register reset values
  localparam logic [DataWidth-1:0] ManufacturerReset = 8'h01;
  localparam logic [DataWidth-1:0] DeviceReset       = 8'h7E;
  localparam logic [DataWidth-1:0] ProtectReset      = 8'h00;

  // ID byte offsets
  localparam logic [7:0] IdOffManufacturer = 8'h00;
  localparam logic [7:0] IdOffDevice       = 8'h01;
  localparam logic [7:0] IdOffProtect      = 8'h02;

  // Unlock addresses, compared on the low 12 bits
  localparam logic [11:0] UnlockAddr1 = 12'h555;
  localparam logic [11:0] UnlockAddr2 = 12'h2AA;

  // Command bytes
  localparam logic [DataWidth-1:0] CmdUnlock1    = 8'hAA;
  localparam logic [DataWidth-1:0] CmdUnlock2    = 8'h55;
  localparam logic [DataWidth-1:0] CmdProgram    = 8'hA0;
  localparam logic [DataWidth-1:0] CmdAutoselect = 8'h90;
  localparam logic [DataWidth-1:0] CmdReset      = 8'hF0;
  localparam logic [DataWidth-1:0] CmdEraseSetup = 8'h80;
  localparam logic [DataWidth-1:0] CmdChipErase  = 8'h10;
  localparam logic [DataWidth-1:0] CmdSectErase  = 8'h30;
  localparam logic [DataWidth-1:0] CmdPageErase  = 8'h50;
  localparam logic [DataWidth-1:0] CmdBypass     = 8'h20;
  localparam logic [DataWidth-1:0] CmdBypassExit = 8'h00;

  // Bus access kind
  localparam logic ModeRead  = 1'b0;
  localparam logic ModeWrite = 1'b1;

  typedef enum logic [2:0] {
    OpNone   = 3'd0,
    OpRead   = 3'd1,
    OpId     = 3'd2,
    OpProg   = 3'd3,
    OpChip   = 3'd4,
    OpSect   = 3'd5,
    OpPage   = 3'd6,
    OpReset  = 3'd7
  } op_e;

  typedef struct packed {
    logic                 mode;
    logic [AddrWidth-1:0] address;
    logic [DataWidth-1:0] write_data;
  } in_item_t;

  typedef struct packed {
    logic [2:0]           operation;
    logic [AddrWidth-1:0] op_address;
    logic [DataWidth-1:0] op_data;
    logic                 bypass_active;
    logic                 autoselect_active;
  } out_item_t;

endpackage

[rtl/core/fcd_id_regs.sv]
// Identification registers of the command decoder and the ID byte select.
// Depends on fcd_pkg.

module fcd_id_regs (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [fcd_pkg::CfgIdxWidth-1:0]      cfg_index_i,
  input  logic [fcd_pkg::DataWidth-1:0]        cfg_data_i,
  input  logic [7:0]                           id_offset_i,
  output logic [fcd_pkg::DataWidth-1:0]        id_byte_o
);

  logic [fcd_pkg::DataWidth-1:0] manufacturer_q;
  logic [fcd_pkg::DataWidth-1:0] device_q;
  logic [fcd_pkg::DataWidth-1:0] protect_q;

  // Always take writes; an index beyond the list is dropped
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      manufacturer_q <= fcd_pkg::ManufacturerReset;
      device_q       <= fcd_pkg::DeviceReset;
      protect_q      <= fcd_pkg::ProtectReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        fcd_pkg::CfgManufacturer: manufacturer_q <= cfg_data_i;
        fcd_pkg::CfgDevice:       device_q       <= cfg_data_i;
        fcd_pkg::CfgProtect:      protect_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Select the ID byte by the low address byte
  always_comb begin
    case (id_offset_i)
      fcd_pkg::IdOffManufacturer: id_byte_o = manufacturer_q;
      fcd_pkg::IdOffDevice:       id_byte_o = device_q;
      fcd_pkg::IdOffProtect:      id_byte_o = protect_q;
      default:                    id_byte_o = '0;
    endcase
  end

endmodule

[rtl/core/fcd_seq.sv]
// Command sequence state machine: unlock, command and bypass decoding.
// Depends on fcd_pkg; the ID byte comes from fcd_id_regs.

module fcd_seq #(
  parameter int unsigned ADDR_BITS = 25
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  fcd_pkg::in_item_t             item_i,
  input  logic [fcd_pkg::DataWidth-1:0] id_byte_i,
  output fcd_pkg::out_item_t            result_o
);

  localparam int unsigned EffBits =
    (ADDR_BITS < fcd_pkg::AddrWidth) ? ADDR_BITS : fcd_pkg::AddrWidth;
  localparam logic [fcd_pkg::AddrWidth-1:0] AddrMask =
    {fcd_pkg::AddrWidth{1'b1}} >> (fcd_pkg::AddrWidth - EffBits);

  typedef enum logic [3:0] {
    StIdle    = 4'd0,
    StUnlk1   = 4'd1,
    StUnlk2   = 4'd2,
    StProg    = 4'd3,
    StErs1    = 4'd4,
    StErs2    = 4'd5,
    StErs3    = 4'd6,
    StBypExit = 4'd7
  } step_e;

  step_e step_q, step_d;
  logic  bypass_q, bypass_d;
  logic  autosel_q, autosel_d;

  logic [fcd_pkg::AddrWidth-1:0] addr;
  logic [11:0]                   a12;
  logic [fcd_pkg::DataWidth-1:0] d;
  fcd_pkg::op_e                  op;
  logic [fcd_pkg::AddrWidth-1:0] oaddr;
  logic [fcd_pkg::DataWidth-1:0] odata;

  assign addr = item_i.address & AddrMask;
  assign a12  = addr[11:0];
  assign d    = item_i.write_data;

  // Decode one access against the current step
  always_comb begin
    op        = fcd_pkg::OpNone;
    oaddr     = '0;
    odata     = '0;
    step_d    = StIdle;
    bypass_d  = bypass_q;
    autosel_d = autosel_q;
    if (item_i.mode == fcd_pkg::ModeRead) begin
      op     = autosel_q ? fcd_pkg::OpId : fcd_pkg::OpRead;
      odata  = autosel_q ? id_byte_i : '0;
      oaddr  = addr;
      step_d = step_q;
    end else if (step_q == StProg) begin
      op    = fcd_pkg::OpProg;
      oaddr = addr;
      odata = d;
    end else if (d == fcd_pkg::CmdReset) begin
      op        = fcd_pkg::OpReset;
      autosel_d = 1'b0;
    end else begin
      case (step_q)
        StUnlk1: begin
          if (d == fcd_pkg::CmdUnlock2 && a12 == fcd_pkg::UnlockAddr2) step_d = StUnlk2;
        end
        StUnlk2: begin
          if (a12 == fcd_pkg::UnlockAddr1) begin
            if (d == fcd_pkg::CmdProgram) step_d = StProg;
            else if (d == fcd_pkg::CmdAutoselect) autosel_d = 1'b1;
            else if (d == fcd_pkg::CmdEraseSetup) step_d = StErs1;
            else if (d == fcd_pkg::CmdBypass) bypass_d = 1'b1;
          end
        end
        StErs1: begin
          if (d == fcd_pkg::CmdUnlock1 && a12 == fcd_pkg::UnlockAddr1) step_d = StErs2;
        end
        StErs2: begin
          if (d == fcd_pkg::CmdUnlock2 && a12 == fcd_pkg::UnlockAddr2) step_d = StErs3;
        end
        StErs3: begin
          if (d == fcd_pkg::CmdChipErase && a12 == fcd_pkg::UnlockAddr1) begin
            op = fcd_pkg::OpChip;
          end else if (d == fcd_pkg::CmdSectErase) begin
            op    = fcd_pkg::OpSect;
            oaddr = addr;
          end else if (d == fcd_pkg::CmdPageErase) begin
            op    = fcd_pkg::OpPage;
            oaddr = addr;
          end
        end
        StBypExit: begin
          if (d == fcd_pkg::CmdBypassExit) bypass_d = 1'b0;
        end
        default: begin
          // Idle, and any step code with no meaning
          if (bypass_q) begin
            if (d == fcd_pkg::CmdProgram) step_d = StProg;
            else if (d == fcd_pkg::CmdAutoselect) step_d = StBypExit;
          end else if (d == fcd_pkg::CmdUnlock1 && a12 == fcd_pkg::UnlockAddr1) begin
            step_d = StUnlk1;
          end
        end
      endcase
    end
  end

  // Advance the sequence on each accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q    <= StIdle;
      bypass_q  <= 1'b0;
      autosel_q <= 1'b0;
    end else if (accept_i) begin
      step_q    <= step_d;
      bypass_q  <= bypass_d;
      autosel_q <= autosel_d;
    end
  end

  assign result_o.operation         = op;
  assign result_o.op_address        = oaddr;
  assign result_o.op_data           = odata;
  assign result_o.bypass_active     = bypass_d;
  assign result_o.autoselect_active = autosel_d;

endmodule

[rtl/core/nor_flash_command_decoder.sv]
// NOR flash command decoder, top level: sequence decoder, ID registers, result register.
// The result item of an accepted access is registered and shows on the output in the next cycle.
// Throughput: one item per cycle; the input stalls only while a result waits on out_ready_i.
// Reset clears the sequence to idle, bypass and autoselect off, and the output register empty;
// ID registers return to their default codes.
// Depends on fcd_pkg, fcd_id_regs and fcd_seq.

module nor_flash_command_decoder #(
  parameter int unsigned ADDR_BITS = 25
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  fcd_pkg::in_item_t                  in_item_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output fcd_pkg::out_item_t                 out_item_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [fcd_pkg::CfgIdxWidth-1:0]    cfg_index_i,
  input  logic [fcd_pkg::DataWidth-1:0]      cfg_data_i
);

  logic                          accept;
  logic [fcd_pkg::DataWidth-1:0] id_byte;
  fcd_pkg::out_item_t            result;
  fcd_pkg::out_item_t            out_q;
  logic                          out_valid_q;

  // Take an item when the result register is empty or drains this cycle
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  fcd_id_regs u_id_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .id_offset_i (in_item_i.address[7:0]),
    .id_byte_o   (id_byte)
  );

  fcd_seq #(
    .ADDR_BITS (ADDR_BITS)
  ) u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .item_i    (in_item_i),
    .id_byte_i (id_byte),
    .result_o  (result)
  );

  // Hold the result until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Every accepted item shows up as a result in the next cycle
  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_o)
    else $error("accepted item produced no result");

  // An ID read only happens with autoselect on
  a_id_needs_autoselect: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.operation == fcd_pkg::OpId) |-> out_item_o.autoselect_active)
    else $error("id read without autoselect");

  // The reset command always leaves autoselect off
  a_reset_clears_autoselect: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.operation == fcd_pkg::OpReset) |-> !out_item_o.autoselect_active)
    else $error("reset command left autoselect on");

  // Operations without a target carry a zero address
  a_no_target_zero_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_item_o.operation == fcd_pkg::OpNone ||
                     out_item_o.operation == fcd_pkg::OpReset ||
                     out_item_o.operation == fcd_pkg::OpChip)) |-> out_item_o.op_address == '0)
    else $error("untargeted operation with nonzero address");

endmodule

[bench/tb_top.sv]
// Self-checking bench for nor_flash_command_decoder: directed command sequences, then random
// bus traffic checked item by item against a cycle-free prediction of the decoder.
// Depends on fcd_pkg and the decoder RTL.

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned DrainCycles = 4;
  localparam int unsigned MaxWait     = 17;
  localparam int unsigned PhaseItems  = 450;
  localparam logic [fcd_pkg::CfgIdxWidth-1:0] CfgUnused = 2'd3;

  typedef enum logic [3:0] {
    StepIdle,
    StepUnlock1,
    StepUnlock2,
    StepProgData,
    StepErase1,
    StepErase2,
    StepErase3,
    StepBypassExit
  } seq_step_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                            in_valid;
  logic                            in_ready_o;
  fcd_pkg::in_item_t               in_item;
  logic                            out_valid_o;
  logic                            out_ready;
  fcd_pkg::out_item_t              out_item_o;
  logic                            cfg_valid;
  logic                            cfg_ready_o;
  logic [fcd_pkg::CfgIdxWidth-1:0] cfg_index;
  logic [fcd_pkg::DataWidth-1:0]   cfg_data;

  // Predicted decoder state and ID registers
  seq_step_e      seq_step;
  logic           bypass_on;
  logic           autosel_on;
  logic [7:0]     mfr_code;
  logic [7:0]     dev_code;
  logic [7:0]     prot_code;

  fcd_pkg::out_item_t expected_results[$];
  int unsigned        err_count;
  int unsigned        items_sent;
  int unsigned        results_seen;
  int unsigned        cycle_count;
  bit                 tx_burst;
  bit                 rx_burst;
  bit                 mix_reads;

  logic [7:0] cmd_pool [11] = '{fcd_pkg::CmdUnlock1, fcd_pkg::CmdUnlock2,
                                fcd_pkg::CmdProgram, fcd_pkg::CmdAutoselect,
                                fcd_pkg::CmdReset, fcd_pkg::CmdEraseSetup,
                                fcd_pkg::CmdChipErase, fcd_pkg::CmdSectErase,
                                fcd_pkg::CmdPageErase, fcd_pkg::CmdBypass,
                                fcd_pkg::CmdBypassExit};

  nor_flash_command_decoder u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Step the predicted command state machine by one access and return its result item
  function automatic fcd_pkg::out_item_t predict_access(fcd_pkg::in_item_t acc);
    fcd_pkg::out_item_t res;
    seq_step_e          nxt;
    logic [11:0]        low12;
    logic [7:0]         d;
    res   = '0;
    nxt   = StepIdle;
    low12 = acc.address[11:0];
    d     = acc.write_data;
    if (acc.mode == fcd_pkg::ModeRead) begin
      res.op_address = acc.address;
      nxt = seq_step;
      if (autosel_on) begin
        res.operation = fcd_pkg::OpId;
        case (acc.address[7:0])
          fcd_pkg::IdOffManufacturer: res.op_data = mfr_code;
          fcd_pkg::IdOffDevice:       res.op_data = dev_code;
          fcd_pkg::IdOffProtect:      res.op_data = prot_code;
          default:                    res.op_data = '0;
        endcase
      end else begin
        res.operation = fcd_pkg::OpRead;
      end
    end else if (seq_step == StepProgData) begin
      // program data step takes any write as the data
      res.operation  = fcd_pkg::OpProg;
      res.op_address = acc.address;
      res.op_data    = d;
    end else if (d == fcd_pkg::CmdReset) begin
      res.operation = fcd_pkg::OpReset;
      autosel_on = 1'b0;
    end else begin
      case (seq_step)
        StepUnlock1: begin
          if (d == fcd_pkg::CmdUnlock2 && low12 == fcd_pkg::UnlockAddr2) nxt = StepUnlock2;
        end
        StepUnlock2: begin
          if (low12 == fcd_pkg::UnlockAddr1) begin
            if (d == fcd_pkg::CmdProgram) nxt = StepProgData;
            else if (d == fcd_pkg::CmdAutoselect) autosel_on = 1'b1;
            else if (d == fcd_pkg::CmdEraseSetup) nxt = StepErase1;
            else if (d == fcd_pkg::CmdBypass) bypass_on = 1'b1;
          end
        end
        StepErase1: begin
          if (d == fcd_pkg::CmdUnlock1 && low12 == fcd_pkg::UnlockAddr1) nxt = StepErase2;
        end
        StepErase2: begin
          if (d == fcd_pkg::CmdUnlock2 && low12 == fcd_pkg::UnlockAddr2) nxt = StepErase3;
        end
        StepErase3: begin
          if (d == fcd_pkg::CmdChipErase && low12 == fcd_pkg::UnlockAddr1) begin
            res.operation = fcd_pkg::OpChip;
          end else if (d == fcd_pkg::CmdSectErase) begin
            res.operation  = fcd_pkg::OpSect;
            res.op_address = acc.address;
          end else if (d == fcd_pkg::CmdPageErase) begin
            res.operation  = fcd_pkg::OpPage;
            res.op_address = acc.address;
          end
        end
        StepBypassExit: begin
          if (d == fcd_pkg::CmdBypassExit) bypass_on = 1'b0;
        end
        default: begin
          if (bypass_on) begin
            if (d == fcd_pkg::CmdProgram) nxt = StepProgData;
            else if (d == fcd_pkg::CmdAutoselect) nxt = StepBypassExit;
          end else if (d == fcd_pkg::CmdUnlock1 && low12 == fcd_pkg::UnlockAddr1) begin
            nxt = StepUnlock1;
          end
        end
      endcase
    end
    seq_step = nxt;
    res.bypass_active     = bypass_on;
    res.autoselect_active = autosel_on;
    return res;
  endfunction

  // Address with the given low 12 bits and random upper bits
  function automatic logic [fcd_pkg::AddrWidth-1:0] at_low12(logic [11:0] low);
    logic [fcd_pkg::AddrWidth-1:0] a;
    a = fcd_pkg::AddrWidth'($urandom);
    a[11:0] = low;
    return a;
  endfunction

  function automatic logic [fcd_pkg::AddrWidth-1:0] rand_addr();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return at_low12(fcd_pkg::UnlockAddr1);
      3:       return at_low12(fcd_pkg::UnlockAddr2);
      default: return fcd_pkg::AddrWidth'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] rand_data();
    if ($urandom_range(0, 2) == 0) return 8'($urandom);
    return cmd_pool[$urandom_range(0, 10)];
  endfunction

  // Drive one item after a random gap and wait until it is accepted
  task automatic send_access(logic m, logic [fcd_pkg::AddrWidth-1:0] a, logic [7:0] d);
    int unsigned gap;
    gap = tx_burst ? 0 : $urandom_range(0, MaxWait);
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid           <= 1'b1;
    in_item.mode       <= m;
    in_item.address    <= a;
    in_item.write_data <= d;
    do @(posedge clk_i); while (!in_ready_o);
    expected_results.push_back(predict_access(in_item));
    items_sent++;
  endtask

  task automatic send_read(logic [fcd_pkg::AddrWidth-1:0] a);
    send_access(fcd_pkg::ModeRead, a, 8'($urandom));
  endtask

  // Write access, now and then preceded by a read that must not disturb the sequence
  task automatic send_write(logic [fcd_pkg::AddrWidth-1:0] a, logic [7:0] d);
    if (mix_reads && $urandom_range(0, 9) == 0) send_read(rand_addr());
    send_access(fcd_pkg::ModeWrite, a, d);
  endtask

  task automatic unlock_cycles();
    send_write(at_low12(fcd_pkg::UnlockAddr1), fcd_pkg::CmdUnlock1);
    send_write(at_low12(fcd_pkg::UnlockAddr2), fcd_pkg::CmdUnlock2);
  endtask

  // Drop valid and hold until every expected item has come back
  task automatic wait_drained();
    if (in_valid) begin
      @(negedge clk_i);
      in_valid <= 1'b0;
    end
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_id_reg(logic [fcd_pkg::CfgIdxWidth-1:0] idx, logic [7:0] val);
    wait_drained();
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      fcd_pkg::CfgManufacturer: mfr_code  = val;
      fcd_pkg::CfgDevice:       dev_code  = val;
      fcd_pkg::CfgProtect:      prot_code = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  task automatic check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      err_count++;
    end
  endtask

  // Enter autoselect and read the reset ID codes, plus an offset past the table
  task automatic test_autoselect_ids();
    unlock_cycles();
    send_write(at_low12(fcd_pkg::UnlockAddr1), fcd_pkg::CmdAutoselect);
    send_read(at_low12({4'h0, fcd_pkg::IdOffManufacturer}));
    send_read(at_low12({4'h3, fcd_pkg::IdOffDevice}));
    send_read(at_low12({4'hF, fcd_pkg::IdOffProtect}));
    send_read(at_low12(12'h0FF));
  endtask

  // Rewrite the ID registers while still in autoselect, then leave with the reset command
  task automatic test_id_regs();
    write_id_reg(fcd_pkg::CfgManufacturer, 8'hFF);
    write_id_reg(fcd_pkg::CfgDevice, 8'hFF);
    write_id_reg(fcd_pkg::CfgProtect, 8'hFF);
    write_id_reg(CfgUnused, 8'h5A);
    send_read(at_low12({4'h5, fcd_pkg::IdOffManufacturer}));
    send_read(at_low12({4'hA, fcd_pkg::IdOffDevice}));
    send_read(at_low12({4'h0, fcd_pkg::IdOffProtect}));
    send_write('1, fcd_pkg::CmdReset);
  endtask

  // Program a reset byte at the top address: the data step must not treat it as a command
  task automatic test_program();
    unlock_cycles();
    send_write(at_low12(fcd_pkg::UnlockAddr1), fcd_pkg::CmdProgram);
    send_write('1, fcd_pkg::CmdReset);
  endtask

  task automatic test_chip_erase();
    unlock_cycles();
    send_write(at_low12(fcd_pkg::UnlockAddr1), fcd_pkg::CmdEraseSetup);
    unlock_cycles();
    send_write(at_low12(fcd_pkg::UnlockAddr1), fcd_pkg::CmdChipErase);
  endtask

  // Enter bypass, program without unlock, then exit
  task automatic test_bypass();
    unlock_cycles();
    send_write(at_low12(fcd_pkg::UnlockAddr1), fcd_pkg::CmdBypass);
    send_write('0, fcd_pkg::CmdProgram);
    send_write('0, 8'h00);
    send_write(rand_addr(), fcd_pkg::CmdAutoselect);
    send_write(rand_addr(), fcd_pkg::CmdBypassExit);
  endtask

  task automatic random_noise(int unsigned n);
    repeat (n) begin
      if ($urandom_range(0, 3) == 0) send_read(rand_addr());
      else send_write(rand_addr(), rand_data());
    end
  endtask

  // Mostly well-formed command sequences with random content, the rest noise and broken ones
  task automatic test_random_phase(int unsigned n);
    int unsigned stop_at;
    int unsigned pick;
    bit          paused;
    stop_at = items_sent + n;
    paused  = 1'b0;
    while (items_sent < stop_at) begin
      tx_burst = ($urandom_range(0, 7) == 0);
      pick = $urandom_range(0, 99);
      if (!paused && items_sent + n / 2 > stop_at) begin
        wait_drained();
        paused = 1'b1;
      end
      if (bypass_on && pick < 50) begin
        if (pick < 30) begin
          send_write(rand_addr(), fcd_pkg::CmdProgram);
          send_write(rand_addr(), 8'($urandom));
        end else if (pick < 42) begin
          send_write(rand_addr(), fcd_pkg::CmdAutoselect);
          send_write(rand_addr(),
                     ($urandom_range(0, 3) == 0) ? rand_data() : fcd_pkg::CmdBypassExit);
        end else begin
          random_noise(1);
        end
      end else if (pick < 18) begin
        unlock_cycles();
        send_write(at_low12(fcd_pkg::UnlockAddr1), fcd_pkg::CmdProgram);
        send_write(rand_addr(), 8'($urandom));
      end else if (pick < 30) begin
        unlock_cycles();
        send_write(at_low12(fcd_pkg::UnlockAddr1), fcd_pkg::CmdAutoselect);
        repeat ($urandom_range(1, 4)) begin
          send_read(at_low12({4'($urandom), 8'($urandom_range(0, 3))}));
        end
        if ($urandom_range(0, 1) == 0) send_write(rand_addr(), fcd_pkg::CmdReset);
      end else if (pick < 45) begin
        unlock_cycles();
        send_write(at_low12(fcd_pkg::UnlockAddr1), fcd_pkg::CmdEraseSetup);
        unlock_cycles();
        case ($urandom_range(0, 3))
          0:       send_write(at_low12(fcd_pkg::UnlockAddr1), fcd_pkg::CmdChipErase);
          1:       send_write(rand_addr(), fcd_pkg::CmdSectErase);
          2:       send_write(rand_addr(), fcd_pkg::CmdPageErase);
          default: send_write(rand_addr(), rand_data());
        endcase
      end else if (pick < 52) begin
        unlock_cycles();
        send_write(at_low12(fcd_pkg::UnlockAddr1), fcd_pkg::CmdBypass);
      end else if (pick < 58) begin
        send_write(rand_addr(), fcd_pkg::CmdReset);
      end else if (pick < 70) begin
        repeat ($urandom_range(1, 4)) send_read(rand_addr());
      end else if (pick < 85) begin
        // break a sequence partway through
        unlock_cycles();
        if ($urandom_range(0, 1) == 0) begin
          send_write(at_low12(fcd_pkg::UnlockAddr1), fcd_pkg::CmdEraseSetup);
          if ($urandom_range(0, 1) == 0) begin
            send_write(at_low12(fcd_pkg::UnlockAddr1), fcd_pkg::CmdUnlock1);
          end
        end
        send_write(rand_addr(), rand_data());
      end else begin
        random_noise($urandom_range(1, 3));
      end
    end
    tx_burst = 1'b0;
  endtask

  // Drive ready with a random stall before each result item
  initial begin : result_sink
    int unsigned stall;
    out_ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = rx_burst ? 0 : $urandom_range(0, MaxWait);
      if (stall > 0) begin
        @(negedge clk_i);
        out_ready <= 1'b0;
        repeat (stall - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready));
      results_seen++;
      if (results_seen % 64 == 0) rx_burst = ($urandom_range(0, 2) == 0);
    end
  end

  // Compare each accepted result item with the oldest prediction
  always @(posedge clk_i) begin : result_check
    fcd_pkg::out_item_t want;
    if (rst_ni && out_valid_o && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("result item with none expected: %p", out_item_o);
        err_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("operation", want.operation, out_item_o.operation);
        check_field("op_address", want.op_address, out_item_o.op_address);
        check_field("op_data", want.op_data, out_item_o.op_data);
        check_field("bypass_active", want.bypass_active, out_item_o.bypass_active);
        check_field("autoselect_active", want.autoselect_active,
                    out_item_o.autoselect_active);
      end
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : main
    rst_ni     = 1'b0;
    in_valid   = 1'b0;
    in_item    = '0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    err_count  = 0;
    items_sent = 0;
    results_seen = 0;
    tx_burst   = 1'b0;
    rx_burst   = 1'b0;
    mix_reads  = 1'b0;
    seq_step   = StepIdle;
    bypass_on  = 1'b0;
    autosel_on = 1'b0;
    mfr_code   = fcd_pkg::ManufacturerReset;
    dev_code   = fcd_pkg::DeviceReset;
    prot_code  = fcd_pkg::ProtectReset;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_autoselect_ids();
    test_id_regs();
    test_program();
    test_chip_erase();
    test_bypass();

    // Random phases, each under its own ID register setting
    mix_reads = 1'b1;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          write_id_reg(fcd_pkg::CfgManufacturer, 8'h00);
          write_id_reg(fcd_pkg::CfgDevice, 8'h00);
          write_id_reg(fcd_pkg::CfgProtect, 8'h00);
        end
        1: begin
          write_id_reg(fcd_pkg::CfgManufacturer, 8'hFF);
          write_id_reg(fcd_pkg::CfgDevice, 8'hFF);
          write_id_reg(fcd_pkg::CfgProtect, 8'hFF);
        end
        default: begin
          write_id_reg(fcd_pkg::CfgManufacturer, 8'($urandom));
          write_id_reg(fcd_pkg::CfgDevice, 8'($urandom));
          write_id_reg(fcd_pkg::CfgProtect, 8'($urandom));
        end
      endcase
      test_random_phase(PhaseItems);
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
